FILE: rtl/stl_pkg.sv
// Package for the steering torque rate limiter.
// Holds widths, register indexes, reset values and the shared clamp helpers.
// No dependencies.
package stl_pkg;

    localparam int TORQUE_WIDTH     = 13;
    localparam int OUT_WIDTH        = 14;
    localparam int TORQUE_CAP_WIDTH = 12;
    localparam int DELTA_WIDTH      = 8;
    localparam int ERROR_MAX_WIDTH  = 12;

    // Working width: holds a torque plus or minus a 12-bit margin without overflow.
    localparam int CALC_WIDTH = ((TORQUE_WIDTH > OUT_WIDTH) ? TORQUE_WIDTH : OUT_WIDTH) + 2;

    localparam int IN_TDATA_WIDTH  = ((3 * TORQUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((OUT_WIDTH + 7) / 8) * 8;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TORQUE_CAP = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELTA_UP   = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELTA_DOWN = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ERROR_MAX  = 8'd3;

    localparam logic [TORQUE_CAP_WIDTH-1:0] TORQUE_CAP_RESET = 12'd1500;
    localparam logic [DELTA_WIDTH-1:0]      DELTA_UP_RESET   = 8'd10;
    localparam logic [DELTA_WIDTH-1:0]      DELTA_DOWN_RESET = 8'd25;
    localparam logic [ERROR_MAX_WIDTH-1:0]  ERROR_MAX_RESET  = 12'd350;

    typedef logic signed [CALC_WIDTH-1:0] calc_t;

    typedef struct packed {
        logic [TORQUE_CAP_WIDTH-1:0] torque_cap;
        logic [DELTA_WIDTH-1:0]      delta_up;
        logic [DELTA_WIDTH-1:0]      delta_down;
        logic [ERROR_MAX_WIDTH-1:0]  error_max;
    } cfg_t;

    function automatic calc_t smax(input calc_t a, input calc_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic calc_t smin(input calc_t a, input calc_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic calc_t clip(input calc_t x, input calc_t lo, input calc_t hi);
        return smin(smax(x, lo), hi);
    endfunction

endpackage

FILE: rtl/stl_cfg_regs.sv
// Configuration register file of the steering torque rate limiter.
// Depends on stl_pkg for register indexes, widths and reset values.
module stl_cfg_regs
    import stl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            // Writes to indexes past the last register are dropped.
            case (cfg_index)
                REG_TORQUE_CAP: cfg_next.torque_cap = cfg_data[TORQUE_CAP_WIDTH-1:0];
                REG_DELTA_UP:   cfg_next.delta_up   = cfg_data[DELTA_WIDTH-1:0];
                REG_DELTA_DOWN: cfg_next.delta_down = cfg_data[DELTA_WIDTH-1:0];
                REG_ERROR_MAX:  cfg_next.error_max  = cfg_data[ERROR_MAX_WIDTH-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.torque_cap <= TORQUE_CAP_RESET;
            cfg_reg.delta_up   <= DELTA_UP_RESET;
            cfg_reg.delta_down <= DELTA_DOWN_RESET;
            cfg_reg.error_max  <= ERROR_MAX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/stl_limit_path.sv
// Limiting datapath: input register, error window and rate clamps, result register.
// Depends on stl_pkg for widths, the configuration struct and the clamp helpers.
module stl_limit_path
    import stl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [TORQUE_WIDTH-1:0]    in_req,
    input  logic [TORQUE_WIDTH-1:0]    in_prev,
    input  logic [TORQUE_WIDTH-1:0]    in_meas,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [OUT_WIDTH-1:0]       out_torque
);

    localparam int EXT_T = CALC_WIDTH - TORQUE_WIDTH;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [TORQUE_WIDTH-1:0] s1_req_reg;
    logic [TORQUE_WIDTH-1:0] s1_prev_reg;
    logic [TORQUE_WIDTH-1:0] s1_meas_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_WIDTH-1:0]    out_torque_reg;
    logic [OUT_WIDTH-1:0]    out_torque_next;

    logic  out_load;
    logic  s1_load;
    calc_t req;
    calc_t prev;
    calc_t meas;
    calc_t smax_v;
    calc_t up_v;
    calc_t down_v;
    calc_t emax_v;
    calc_t win_hi;
    calc_t win_lo;
    calc_t t_win;
    calc_t rate_hi;
    calc_t rate_lo;
    calc_t t_rate;
    calc_t t_sat;

    localparam calc_t OUT_MAX = calc_t'((1 << (OUT_WIDTH - 1)) - 1);
    localparam calc_t OUT_MIN = calc_t'(-(1 << (OUT_WIDTH - 1)));

    // The result register takes a new item when it is empty or being drained.
    assign out_load  = !out_valid_reg || out_ready;
    assign s1_load   = !s1_valid_reg || out_load;
    assign in_ready  = s1_load;
    assign out_valid = out_valid_reg;
    assign out_torque = out_torque_reg;

    always_comb
    begin
        req    = $signed({{EXT_T{s1_req_reg[TORQUE_WIDTH-1]}}, s1_req_reg});
        prev   = $signed({{EXT_T{s1_prev_reg[TORQUE_WIDTH-1]}}, s1_prev_reg});
        meas   = $signed({{EXT_T{s1_meas_reg[TORQUE_WIDTH-1]}}, s1_meas_reg});
        smax_v = $signed({{(CALC_WIDTH-TORQUE_CAP_WIDTH){1'b0}}, cfg.torque_cap});
        up_v   = $signed({{(CALC_WIDTH-DELTA_WIDTH){1'b0}}, cfg.delta_up});
        down_v = $signed({{(CALC_WIDTH-DELTA_WIDTH){1'b0}}, cfg.delta_down});
        emax_v = $signed({{(CALC_WIDTH-ERROR_MAX_WIDTH){1'b0}}, cfg.error_max});

        // Window around the measured torque, never past the absolute maximum.
        win_hi = smin(smax(meas + emax_v, emax_v), smax_v);
        win_lo = smax(smin(meas - emax_v, -emax_v), -smax_v);
        t_win  = clip(req, win_lo, win_hi);

        // Growth in magnitude is bounded by delta_up, decay by delta_down.
        if (prev > calc_t'(0))
        begin
            rate_lo = smax(prev - down_v, -up_v);
            rate_hi = prev + up_v;
        end
        else
        begin
            rate_lo = prev - up_v;
            rate_hi = smin(prev + down_v, up_v);
        end
        t_rate = clip(t_win, rate_lo, rate_hi);
        t_sat  = clip(t_rate, OUT_MIN, OUT_MAX);
        out_torque_next = t_sat[OUT_WIDTH-1:0];

        s1_valid_next  = s1_load ? in_valid : s1_valid_reg;
        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_req_reg  <= in_req;
            s1_prev_reg <= in_prev;
            s1_meas_reg <= in_meas;
        end
        if (out_load && s1_valid_reg)
        begin
            out_torque_reg <= out_torque_next;
        end
    end

endmodule

FILE: rtl/steer_torque_rate_limiter.sv
// Top level of the steering torque rate limiter.
// Depends on stl_pkg, stl_cfg_regs and stl_limit_path.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | requested, previous, measured torque
//  m_axis   | out       | m_axis_tvalid/tready    | limited torque
//  cfg      | in        | cfg_valid/cfg_ready     | register index and write data
//
// While s_axis_tready is high, one item per cycle is accepted; an item is taken into
// the input register, and its result is then loaded into the result register, from
// which it is offered on m_axis.
// Reset clears both valid flags and restores the register defaults.
// A stalled result holds in the result register while one more item waits in
// the input register; s_axis_tready falls only when both are full.
module steer_torque_rate_limiter
    import stl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: requested_torque, previous_torque, measured_torque, zero fill.
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // Fields from bit 0: limited_torque, zero fill.
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t                 cfg;
    logic [OUT_WIDTH-1:0] limited_torque;

    stl_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stl_limit_path u_limit_path
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_req     (s_axis_tdata[TORQUE_WIDTH-1:0]),
        .in_prev    (s_axis_tdata[2*TORQUE_WIDTH-1:TORQUE_WIDTH]),
        .in_meas    (s_axis_tdata[3*TORQUE_WIDTH-1:2*TORQUE_WIDTH]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_torque (limited_torque)
    );

    assign m_axis_tdata = {{(OUT_TDATA_WIDTH-OUT_WIDTH){1'b0}}, limited_torque};

endmodule
